// ===== sv/tterm_pkg.sv =====
// Shared constants, types and helpers for the text terminal cell writer.
// No dependencies; used by tterm_screen and text_terminal_cell_writer_core.
package tterm_pkg;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int TAB_WIDTH     = 8;
    localparam int CELL_COUNT    = ROWS * COLUMNS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;
    localparam int CHAR_W = 8;
    localparam int ACT_W  = 2;

    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CODE_LAST      = 8'h7F;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // Screen store operations
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_READ   = 3'd2,
        OP_FILL   = 3'd3,
        OP_SCROLL = 3'd4
    } scr_op_t;

    typedef struct packed {
        scr_op_t             op;
        logic [ADDR_W-1:0]   addr;
        logic [CELL_W-1:0]   data;
    } scr_cmd_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [CELL_W-1:0]   rdata;
    } scr_stat_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    function automatic logic [CELL_W-1:0] blank_cell(input logic [ATTR_W-1:0] attr);
        blank_cell = {attr, CODE_SPACE};
    endfunction

endpackage

// ===== sv/tterm_screen.sv =====
// Screen store with its sweep engine: single writes, single reads, fill and scroll-up.
// Depends on tterm_pkg.
module tterm_screen (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tterm_pkg::scr_cmd_t  cmd,
    output tterm_pkg::scr_stat_t stat
);

    logic [tterm_pkg::CELL_W-1:0] mem [tterm_pkg::CELL_COUNT];

    logic                         run_reg;
    logic                         scroll_reg;
    logic [tterm_pkg::ADDR_W-1:0] k_reg;
    logic [tterm_pkg::CELL_W-1:0] fill_reg;
    logic                         st_we_reg;
    logic                         st_last_reg;
    logic [tterm_pkg::ADDR_W-1:0] st_addr_reg;
    logic                         st_copy_reg;
    logic [tterm_pkg::CELL_W-1:0] st_data_reg;
    logic [tterm_pkg::CELL_W-1:0] rdata_reg;

    logic                         rd_en;
    logic [tterm_pkg::ADDR_W-1:0] rd_addr;
    logic [tterm_pkg::ADDR_W-1:0] src_addr;
    logic                         copy_row;
    logic                         last_k;
    logic [tterm_pkg::CELL_W-1:0] wdata;

    // shared address unit: source of a scroll copy sits one row further on
    assign src_addr = k_reg + tterm_pkg::ADDR_W'(tterm_pkg::COLUMNS);
    assign copy_row = scroll_reg && (k_reg < tterm_pkg::ADDR_W'(tterm_pkg::LAST_ROW_BASE));
    assign last_k   = (k_reg == tterm_pkg::ADDR_W'(tterm_pkg::CELL_COUNT - 1));
    assign wdata    = st_copy_reg ? rdata_reg : st_data_reg;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = cmd.addr;
        if (run_reg) begin
            rd_en   = copy_row;
            rd_addr = src_addr;
        end else if (cmd.op == tterm_pkg::OP_READ) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            st_we_reg   <= 1'b0;
            st_last_reg <= 1'b0;
        end else if (run_reg) begin
            st_we_reg   <= 1'b1;
            st_last_reg <= last_k;
            run_reg     <= !last_k;
        end else begin
            unique case (cmd.op) inside
                tterm_pkg::OP_WRITE: begin
                    st_we_reg   <= 1'b1;
                    st_last_reg <= 1'b1;
                end
                tterm_pkg::OP_READ: begin
                    st_we_reg   <= 1'b0;
                    st_last_reg <= 1'b1;
                end
                tterm_pkg::OP_FILL, tterm_pkg::OP_SCROLL: begin
                    run_reg     <= 1'b1;
                    st_we_reg   <= 1'b0;
                    st_last_reg <= 1'b0;
                end
                default: begin
                    st_we_reg   <= 1'b0;
                    st_last_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (run_reg) begin
            k_reg       <= k_reg + 1'b1;
            st_addr_reg <= k_reg;
            st_copy_reg <= copy_row;
            st_data_reg <= fill_reg;
        end else begin
            k_reg       <= '0;
            scroll_reg  <= (cmd.op == tterm_pkg::OP_SCROLL);
            fill_reg    <= cmd.data;
            st_addr_reg <= cmd.addr;
            st_copy_reg <= 1'b0;
            st_data_reg <= cmd.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we_reg) begin
            mem[st_addr_reg] <= wdata;
        end
    end

    assign stat.busy  = run_reg | st_we_reg | st_last_reg;
    assign stat.done  = st_last_reg;
    assign stat.rdata = rdata_reg;

endmodule

// ===== sv/text_terminal_cell_writer_core.sv =====
// Top level of the text terminal cell writer: cursor control, sequencer and ports.
// Depends on tterm_pkg and tterm_screen.
//
// Character-cell terminal over an 80 x 25 store of 16-bit cells (attribute in the
// high byte, code in the low byte). Each input transaction is one action: put a
// character (newline, backspace, carriage return, tab and printable codes 0x20..0x7F;
// every other byte leaves the screen alone), clear the screen, or read one cell.
// Every action answers with exactly one result transaction carrying the cursor.
// The block handles one action at a time and holds s_ready low while it works; a
// finished result waits in the output register without blocking the next action.
// A character that only moves the cursor, an ignored byte, the unused action or a
// read past the store leaves the screen store alone; a written character or a cell
// read issues one command to it, and a scroll or a clear runs the sweep engine in
// tterm_screen, which visits all 2000 cells at one cell per cycle (a written character
// that scrolls does both, the write first). After reset the same engine runs a clearing
// pass over the store, and s_ready first rises once that pass has finished;
// configuration writes are taken throughout. The attribute register applies only to
// cells written or blanked after it changes.
module text_terminal_cell_writer_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tterm_pkg::ATTR_W-1:0] cfg_text_attribute,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tterm_pkg::ACT_W-1:0]  s_action,
    input  logic [tterm_pkg::CHAR_W-1:0] s_char_code,
    input  logic [tterm_pkg::ADDR_W-1:0] s_cell_index,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tterm_pkg::ROW_W-1:0]  m_cursor_row,
    output logic [tterm_pkg::COL_W-1:0]  m_cursor_col,
    output logic [tterm_pkg::ADDR_W-1:0] m_cursor_position,
    output logic [tterm_pkg::CELL_W-1:0] m_read_data,
    output logic                         m_scrolled
);

    localparam int COL_XW = tterm_pkg::COL_W + 1;
    localparam int ROW_XW = tterm_pkg::ROW_W + 1;

    typedef enum logic [3:0] {
        ST_INIT = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_BUSY = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                        state_reg;
    tterm_pkg::scr_op_t            cmd_op_reg;
    logic [tterm_pkg::ADDR_W-1:0]  cmd_addr_reg;
    logic [tterm_pkg::CELL_W-1:0]  cmd_data_reg;
    logic [tterm_pkg::ATTR_W-1:0]  attr_reg;
    logic [tterm_pkg::ROW_W-1:0]   row_reg;
    logic [tterm_pkg::COL_W-1:0]   col_reg;
    logic                          pend_scroll_reg;
    logic                          m_valid_reg;
    logic                          scrolled_reg;
    logic                          rd_sel_reg;
    logic [tterm_pkg::CELL_W-1:0]  data_reg;
    logic [tterm_pkg::ROW_W-1:0]   m_row_reg;
    logic [tterm_pkg::COL_W-1:0]   m_col_reg;
    logic [tterm_pkg::ADDR_W-1:0]  m_pos_reg;
    logic [tterm_pkg::CELL_W-1:0]  m_data_reg;
    logic                          m_scrolled_reg;

    tterm_pkg::scr_cmd_t           scr_cmd;
    tterm_pkg::scr_stat_t          scr_stat;

    logic                          s_acc;
    logic                          out_load;
    logic [COL_XW-1:0]             col_calc;
    logic [ROW_XW-1:0]             row_calc;
    logic                          put_write;
    logic                          put_scroll;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign scr_cmd.op   = cmd_op_reg;
    assign scr_cmd.addr = cmd_addr_reg;
    assign scr_cmd.data = cmd_data_reg;

    tterm_screen u_screen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (scr_cmd),
        .stat    (scr_stat)
    );

    // Cursor movement for a put action: control code first, then column wrap,
    // then scroll when the row runs past the bottom.
    always_comb begin
        col_calc  = {1'b0, col_reg};
        row_calc  = {1'b0, row_reg};
        put_write = 1'b0;
        unique case (s_char_code)
            tterm_pkg::CODE_NEWLINE: begin
                col_calc = '0;
                row_calc = row_calc + 1'b1;
            end
            tterm_pkg::CODE_BACKSPACE: begin
                // at column zero a backspace does nothing
                if (col_reg != '0) begin
                    col_calc = col_calc - 1'b1;
                end
            end
            tterm_pkg::CODE_RETURN: begin
                col_calc = '0;
            end
            tterm_pkg::CODE_TAB: begin
                col_calc = col_calc + COL_XW'(tterm_pkg::TAB_WIDTH)
                         - (col_calc % COL_XW'(tterm_pkg::TAB_WIDTH));
            end
            default: begin
                if (s_char_code >= tterm_pkg::CODE_SPACE &&
                    s_char_code <= tterm_pkg::CODE_LAST) begin
                    put_write = 1'b1;
                    col_calc  = col_calc + 1'b1;
                end
            end
        endcase
        if (col_calc >= COL_XW'(tterm_pkg::COLUMNS)) begin
            col_calc = '0;
            row_calc = row_calc + 1'b1;
        end
        put_scroll = (row_calc >= ROW_XW'(tterm_pkg::ROWS));
        if (put_scroll) begin
            row_calc = ROW_XW'(tterm_pkg::ROWS - 1);
        end
    end

    // Sequencer. Reset leaves a fill command waiting so that the store is
    // blanked with the reset attribute as soon as reset is released.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_INIT;
            cmd_op_reg      <= tterm_pkg::OP_FILL;
            cmd_addr_reg    <= '0;
            cmd_data_reg    <= tterm_pkg::blank_cell(tterm_pkg::RESET_ATTR);
            attr_reg        <= tterm_pkg::RESET_ATTR;
            row_reg         <= '0;
            col_reg         <= '0;
            pend_scroll_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                attr_reg <= cfg_text_attribute;
            end
            // drop the result once taken, unless a new one loads at this edge
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT: begin
                    // the fill command left by reset lasts one cycle
                    cmd_op_reg <= tterm_pkg::OP_NONE;
                    if (scr_stat.done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        unique case (s_action)
                            tterm_pkg::ACT_PUT: begin
                                row_reg <= row_calc[tterm_pkg::ROW_W-1:0];
                                col_reg <= col_calc[tterm_pkg::COL_W-1:0];
                                cmd_addr_reg <= tterm_pkg::cell_addr(row_reg, col_reg);
                                if (put_write) begin
                                    // write first, scroll afterwards if needed
                                    cmd_op_reg      <= tterm_pkg::OP_WRITE;
                                    cmd_data_reg    <= {attr_reg, s_char_code};
                                    pend_scroll_reg <= put_scroll;
                                    state_reg       <= ST_BUSY;
                                end else if (put_scroll) begin
                                    cmd_op_reg      <= tterm_pkg::OP_SCROLL;
                                    cmd_data_reg    <= tterm_pkg::blank_cell(attr_reg);
                                    pend_scroll_reg <= 1'b0;
                                    state_reg       <= ST_BUSY;
                                end else begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            tterm_pkg::ACT_CLEAR: begin
                                row_reg         <= '0;
                                col_reg         <= '0;
                                cmd_op_reg      <= tterm_pkg::OP_FILL;
                                cmd_data_reg    <= tterm_pkg::blank_cell(attr_reg);
                                pend_scroll_reg <= 1'b0;
                                state_reg       <= ST_BUSY;
                            end
                            tterm_pkg::ACT_READ: begin
                                cmd_addr_reg <= s_cell_index;
                                // an index beyond the store reads zero
                                if (s_cell_index <
                                    tterm_pkg::ADDR_W'(tterm_pkg::CELL_COUNT)) begin
                                    cmd_op_reg      <= tterm_pkg::OP_READ;
                                    pend_scroll_reg <= 1'b0;
                                    state_reg       <= ST_BUSY;
                                end else begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_BUSY: begin
                    if (scr_stat.done && pend_scroll_reg) begin
                        cmd_op_reg      <= tterm_pkg::OP_SCROLL;
                        cmd_data_reg    <= tterm_pkg::blank_cell(attr_reg);
                        pend_scroll_reg <= 1'b0;
                    end else begin
                        // commands to the screen engine last one cycle
                        cmd_op_reg <= tterm_pkg::OP_NONE;
                        if (scr_stat.done) begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    cmd_op_reg <= tterm_pkg::OP_NONE;
                    state_reg  <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload: gather during the action, then load the output register
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            scrolled_reg <= (s_action == tterm_pkg::ACT_PUT) && put_scroll;
            rd_sel_reg   <= (s_action == tterm_pkg::ACT_READ);
            data_reg     <= '0;
        end
        if ((state_reg == ST_BUSY) && scr_stat.done && rd_sel_reg) begin
            data_reg <= scr_stat.rdata;
        end
        if (out_load) begin
            m_row_reg      <= row_reg;
            m_col_reg      <= col_reg;
            m_pos_reg      <= tterm_pkg::cell_addr(row_reg, col_reg);
            m_data_reg     <= data_reg;
            m_scrolled_reg <= scrolled_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cursor_row      = m_row_reg;
    assign m_cursor_col      = m_col_reg;
    assign m_cursor_position = m_pos_reg;
    assign m_read_data       = m_data_reg;
    assign m_scrolled        = m_scrolled_reg;

    // no new transaction while the sweep engine still owns the store
    a_idle_engine: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !scr_stat.busy)
        else $error("input accepted while screen engine busy");

    // engine completions only arrive while the sequencer waits for them
    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        scr_stat.done |-> (state_reg == ST_BUSY || state_reg == ST_INIT))
        else $error("unexpected screen engine completion");

    // a scroll always leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_scrolled) |->
            (m_cursor_row == tterm_pkg::ROW_W'(tterm_pkg::ROWS - 1)))
        else $error("scroll result not on last row");

    // linear position agrees with row and column
    a_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cursor_position == tterm_pkg::cell_addr(m_cursor_row, m_cursor_col)))
        else $error("cursor position mismatch");

endmodule
